### design/kcst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kcst_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam int ID_W     = 63;
	localparam int CHARGE_W = 24;
	localparam int SLOT_W   = 6;
	localparam int COUNT_W  = 16;
	localparam int SUM_W    = 32;
	localparam int USED_W   = 7;

	typedef enum logic [0:0] {
		ACT_ADD  = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_EXISTING = 2'd0,
		ST_NEW      = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		action_t               action;
		logic [ID_W-1:0]       event_id;
		logic [CHARGE_W-1:0]   charge;
		logic [SLOT_W-1:0]     slot_index;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_W-1:0]     slot;
		logic [ID_W-1:0]       stored_id;
		logic [COUNT_W-1:0]    hit_count;
		logic [SUM_W-1:0]      energy_sum;
		logic [USED_W-1:0]     entries_used;
	} rsp_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic                  look;
		logic                  upd;
		logic                  add_new;
		logic                  is_read;
		logic [ID_W-1:0]       key;
		logic [CHARGE_W-1:0]   charge;
		logic [SLOT_W-1:0]     slot_index;
	} cell_ctl_t;

	// what a selected cell drives back, all zeros when not selected
	typedef struct packed {
		logic                  hit;
		logic [SLOT_W-1:0]     slot;
		logic [ID_W-1:0]       id;
		logic [COUNT_W-1:0]    cnt;
		logic [SUM_W-1:0]      sum;
	} cell_rd_t;

endpackage

`default_nettype wire

### design/kcst_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module kcst_cell #(
	parameter int TABLE_DEPTH = kcst_pkg::TABLE_DEPTH_DEF,
	parameter int IDX         = 0,
	localparam int UW         = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire kcst_pkg::cell_ctl_t ctl,
	input  wire logic [UW-1:0]       used,
	output kcst_pkg::cell_rd_t       rd
);

	localparam int SLOT_SPAN = 1 << kcst_pkg::SLOT_W;

	logic [kcst_pkg::ID_W-1:0]    id_q;
	logic [kcst_pkg::COUNT_W-1:0] cnt_q;
	logic [kcst_pkg::SUM_W-1:0]   sum_q;
	logic                         hit_q;

	logic                         occupied;
	logic                         idx_match;
	logic                         hit_d;
	logic                         is_new;
	logic [kcst_pkg::SUM_W:0]     sum_wide;
	logic [kcst_pkg::SUM_W-1:0]   sum_sat;
	logic [kcst_pkg::COUNT_W-1:0] cnt_sat;

	assign occupied = used > UW'(IDX);

	// only the first slots are reachable by a read index
	if (IDX < SLOT_SPAN) begin : g_readable
		assign idx_match = ctl.slot_index == kcst_pkg::SLOT_W'(IDX);
	end else begin : g_unreadable
		assign idx_match = 1'b0;
	end

	assign hit_d = occupied && (ctl.is_read ? idx_match : (id_q == ctl.key));
	assign is_new = ctl.add_new && (used == UW'(IDX));

	assign sum_wide = {1'b0, sum_q} + (kcst_pkg::SUM_W + 1)'(ctl.charge);
	assign sum_sat  = sum_wide[kcst_pkg::SUM_W] ? '1 : sum_wide[kcst_pkg::SUM_W-1:0];
	assign cnt_sat  = (cnt_q == '1) ? cnt_q : cnt_q + kcst_pkg::COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.look) begin
			hit_q <= hit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (is_new) begin
			id_q  <= ctl.key;
			cnt_q <= kcst_pkg::COUNT_W'(1);
			sum_q <= kcst_pkg::SUM_W'(ctl.charge);
		end else if (ctl.upd && hit_q && !ctl.is_read) begin
			cnt_q <= cnt_sat;
			sum_q <= sum_sat;
		end
	end

	always_comb begin
		rd = '0;
		if (hit_q) begin
			rd.hit  = 1'b1;
			rd.slot = kcst_pkg::SLOT_W'(IDX);
			rd.id   = id_q;
			rd.cnt  = ctl.is_read ? cnt_q : cnt_sat;
			rd.sum  = ctl.is_read ? sum_q : sum_sat;
		end
	end

endmodule

`default_nettype wire

### design/keyed_count_and_sum_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | valid     | stall     | payload
// --------+-----------+-----------+-------------------------
// request | req_valid | req_stall | req (kcst_pkg::req_t)
// result  | rsp_valid | rsp_stall | rsp (kcst_pkg::rsp_t)
//
// each item passes a look state, where every cell compares the key (or the
// slot number) at once, then an update state, where the matching cell
// updates and the result is loaded; the next request transfers during it.
// arst_n clears the fill count, the sequencer and the result valid; cell
// contents are not reset. a stalled result holds the sequencer in its update
// cycle, and the table is written only when the result register loads.

module keyed_count_and_sum_table_top #(
	parameter int TABLE_DEPTH = kcst_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire kcst_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output kcst_pkg::rsp_t      rsp
);

	localparam int UW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t              state_q;
	kcst_pkg::req_t      item_q;
	logic [UW-1:0]       used_q;
	logic                rsp_valid_q;
	kcst_pkg::rsp_t      rsp_q;

	kcst_pkg::cell_ctl_t ctl;
	kcst_pkg::cell_rd_t  rd [TABLE_DEPTH];
	kcst_pkg::cell_rd_t  rd_all;

	logic                rsp_load;
	logic                req_fire;
	logic                upd_fire;
	logic                is_read;
	logic                full;
	logic [UW-1:0]       used_nxt;
	kcst_pkg::rsp_t      rsp_d;

	assign rsp_load  = !rsp_valid_q || !rsp_stall;
	assign upd_fire  = (state_q == S_UPD) && rsp_load;
	assign req_stall = !((state_q == S_IDLE) || upd_fire);
	assign req_fire  = req_valid && !req_stall;

	assign is_read = item_q.action == kcst_pkg::ACT_READ;
	assign full    = used_q == UW'(TABLE_DEPTH);

	always_comb begin
		rd_all = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			rd_all = rd_all | rd[i];
		end
	end

	always_comb begin
		ctl            = '0;
		ctl.look       = state_q == S_LOOK;
		ctl.upd        = upd_fire;
		ctl.is_read    = is_read;
		ctl.add_new    = upd_fire && !is_read && !rd_all.hit && !full;
		ctl.key        = item_q.event_id;
		ctl.charge     = item_q.charge;
		ctl.slot_index = item_q.slot_index;
	end

	assign used_nxt = ctl.add_new ? used_q + UW'(1) : used_q;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		kcst_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.IDX        (g)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.used  (used_q),
			.rd    (rd[g])
		);
	end

	always_comb begin
		rsp_d              = '0;
		rsp_d.entries_used = kcst_pkg::USED_W'(used_nxt);
		if (rd_all.hit) begin
			rsp_d.status     = kcst_pkg::ST_EXISTING;
			rsp_d.slot       = rd_all.slot;
			rsp_d.stored_id  = rd_all.id;
			rsp_d.hit_count  = rd_all.cnt;
			rsp_d.energy_sum = rd_all.sum;
		end else if (is_read) begin
			rsp_d.status = kcst_pkg::ST_EMPTY;
			rsp_d.slot   = item_q.slot_index;
		end else if (!full) begin
			rsp_d.status     = kcst_pkg::ST_NEW;
			rsp_d.slot       = kcst_pkg::SLOT_W'(used_q);
			rsp_d.stored_id  = item_q.event_id;
			rsp_d.hit_count  = kcst_pkg::COUNT_W'(1);
			rsp_d.energy_sum = kcst_pkg::SUM_W'(item_q.charge);
		end else begin
			rsp_d.status = kcst_pkg::ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			used_q <= used_nxt;
			if (req_fire) begin
				state_q <= S_LOOK;
			end else begin
				unique case (state_q)
					S_IDLE:  state_q <= S_IDLE;
					S_LOOK:  state_q <= S_UPD;
					S_UPD:   state_q <= upd_fire ? S_IDLE : S_UPD;
					default: state_q <= S_IDLE;
				endcase
			end
			if (upd_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q <= req;
		end
		if (upd_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
